[design/hrf_pkg.sv]
// ----------------------------------------------------------------------------
// hrf_pkg
// Shared types and constants for the HTTP request framer.
// ----------------------------------------------------------------------------
`default_nettype none

package hrf_pkg;

    // Width of the reported content length field
    localparam int RESULT_LEN_W = 32;

    // Header name matching
    localparam int          NAME_W   = 4;
    localparam logic [3:0]  NAME_LEN = 4'd14;

    // ASCII codes used by the framer
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    // One result word as it leaves the framer
    typedef struct packed {
        logic [7:0]              data_out;
        logic                    in_body;
        logic                    header_done;
        logic                    request_end;
        logic                    has_length;
        logic                    length_invalid;
        logic                    length_overflow;
        logic [RESULT_LEN_W-1:0] content_length;
    } hrf_result_t;

    // Upper-case spelling of the length header name, one letter per position
    function automatic logic [7:0] name_char(input logic [NAME_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h4F; // O
            4'd2:    ch = 8'h4E; // N
            4'd3:    ch = 8'h54; // T
            4'd4:    ch = 8'h45; // E
            4'd5:    ch = 8'h4E; // N
            4'd6:    ch = 8'h54; // T
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h4C; // L
            4'd9:    ch = 8'h45; // E
            4'd10:   ch = 8'h4E; // N
            4'd11:   ch = 8'h47; // G
            4'd12:   ch = 8'h54; // T
            4'd13:   ch = 8'h48; // H
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

[design/hrf_if.sv]
// ----------------------------------------------------------------------------
// hrf_in_if / hrf_out_if
// Valid/ready channels of the framer: raw request bytes in, framed words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;

    modport source (output valid, output data_in, input ready);
    modport sink   (input valid, input data_in, output ready);
endinterface

interface hrf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_out;
    logic        in_body;
    logic        header_done;
    logic        request_end;
    logic        has_length;
    logic        length_invalid;
    logic        length_overflow;
    logic [31:0] content_length;

    modport source (
        output valid, output data_out, output in_body, output header_done,
        output request_end, output has_length, output length_invalid,
        output length_overflow, output content_length, input ready
    );
    modport sink (
        input valid, input data_out, input in_body, input header_done,
        input request_end, input has_length, input length_invalid,
        input length_overflow, input content_length, output ready
    );
endinterface

`default_nettype wire

[design/hrf_in_stage.sv]
// ----------------------------------------------------------------------------
// hrf_in_stage
// Input register: holds one request byte until the framer core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hrf_in_stage
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    hrf_in_if.sink     rx,
    input  wire logic  take,
    output logic       valid,
    output logic [7:0] data
);

    logic       valid_reg;
    logic [7:0] data_reg;

    // Free when empty or when the held byte leaves this cycle
    assign rx.ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            data_reg <= rx.data_in;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

[design/hrf_core.sv]
// ----------------------------------------------------------------------------
// hrf_core
// Per-byte framing state: line end tracking, length header match, value
// parse and body count. Updates once per word taken from the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module hrf_core
    import hrf_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic [7:0] data_in,
    output hrf_result_t     result
);

    localparam int ACC_W = LENGTH_BITS + 4;

    typedef enum logic {
        PH_HEADER,
        PH_BODY
    } phase_t;

    typedef enum logic [2:0] {
        TRK_NONE,
        TRK_CR,
        TRK_CRLF,
        TRK_CRLFCR,
        TRK_LF
    } tracker_t;

    typedef enum logic [2:0] {
        VS_LEAD,
        VS_PLUS,
        VS_MINUS,
        VS_DIGITS,
        VS_NEGZERO,
        VS_TRAIL,
        VS_BAD
    } vstate_t;

    // State registers
    phase_t                  phase_reg,   phase_next,   upd_phase;
    tracker_t                trk_reg,     trk_next,     upd_trk;
    logic [NAME_W-1:0]       pos_reg,     pos_next,     upd_pos;
    logic                    mism_reg,    mism_next,    upd_mism;
    logic                    colon_reg,   colon_next,   upd_colon;
    logic                    capt_reg,    capt_next,    upd_capt;
    vstate_t                 vst_reg,     vst_next,     upd_vst;
    logic [LENGTH_BITS-1:0]  len_reg,     len_next,     upd_len;
    logic                    inv_reg,     inv_next,     upd_inv;
    logic                    ovf_reg,     ovf_next,     upd_ovf;
    logic [LENGTH_BITS-1:0]  rem_reg,     rem_next,     upd_rem;
    logic                    sdone_reg,   sdone_next,   upd_sdone;

    logic                    body_flag;
    logic                    hdone_flag;
    logic                    rend_flag;
    logic                    prev_cr;
    logic                    is_blank;
    logic                    is_digit;
    logic                    val_active;
    logic [7:0]              upper;
    logic [ACC_W-1:0]        acc_sum;
    logic                    acc_ovf;
    logic [RESULT_LEN_W-1:0] len_clip;

    // Character classes of the current byte
    assign is_blank = (data_in == CH_SPACE) || (data_in == CH_TAB);
    assign is_digit = (data_in >= CH_ZERO) && (data_in <= CH_NINE);
    assign prev_cr  = (trk_reg == TRK_CR) || (trk_reg == TRK_CRLFCR);

    // Value chars count only on the first matching length line
    assign val_active = colon_reg && !mism_reg && (pos_reg == NAME_LEN) &&
                        !capt_reg && !sdone_reg;

    // Next decimal accumulation: len * 10 + digit, overflow past LENGTH_BITS
    assign acc_sum = {1'b0, len_reg, 3'b000} + {3'b000, len_reg, 1'b0}
                   + ACC_W'(data_in[3:0]);
    assign acc_ovf = |acc_sum[ACC_W-1:LENGTH_BITS];

    always_comb
    begin
        upper = data_in;
        if (data_in inside {[CH_LOWER_A:CH_LOWER_Z]})
        begin
            upper = data_in - CASE_DELTA;
        end
    end

    // Per-byte state update
    always_comb
    begin
        upd_phase  = phase_reg;
        upd_trk    = trk_reg;
        upd_pos    = pos_reg;
        upd_mism   = mism_reg;
        upd_colon  = colon_reg;
        upd_capt   = capt_reg;
        upd_vst    = vst_reg;
        upd_len    = len_reg;
        upd_inv    = inv_reg;
        upd_ovf    = ovf_reg;
        upd_rem    = rem_reg;
        upd_sdone  = sdone_reg;
        body_flag  = 1'b0;
        hdone_flag = 1'b0;
        rend_flag  = 1'b0;

        if (phase_reg == PH_BODY)
        begin
            // Body byte: count down the remaining length
            body_flag = 1'b1;
            if (rem_reg != '0)
            begin
                upd_rem = rem_reg - LENGTH_BITS'(1);
            end
            if (upd_rem == '0)
            begin
                rend_flag = 1'b1;
            end
        end
        else
        begin
            // A pending CR not followed by LF is an ordinary character
            if (prev_cr && (data_in != CH_LF))
            begin
                if (!upd_colon)
                begin
                    upd_mism = 1'b1;
                    if (upd_pos != NAME_LEN)
                    begin
                        upd_pos = upd_pos + 4'd1;
                    end
                end
                else if (val_active)
                begin
                    upd_vst = VS_BAD;
                end
            end

            if (data_in == CH_LF)
            begin
                // Line end: empty line stops the search, length line is taken
                if ((pos_reg == '0) && !colon_reg)
                begin
                    upd_sdone = 1'b1;
                end
                else if (val_active)
                begin
                    upd_capt  = 1'b1;
                    upd_sdone = 1'b1;
                    if (!(vst_reg inside {VS_DIGITS, VS_NEGZERO, VS_TRAIL}))
                    begin
                        upd_len = '0;
                        upd_inv = 1'b1;
                        upd_ovf = 1'b0;
                    end
                end
                upd_pos   = '0;
                upd_mism  = 1'b0;
                upd_colon = 1'b0;
                upd_vst   = VS_LEAD;

                case (trk_reg)
                    TRK_NONE: upd_trk = TRK_LF;
                    TRK_CR:   upd_trk = TRK_CRLF;
                    default:
                    begin
                        upd_trk    = TRK_NONE;
                        hdone_flag = 1'b1;
                    end
                endcase
            end
            else if (data_in == CH_CR)
            begin
                upd_trk = (trk_reg == TRK_CRLF) ? TRK_CRLFCR : TRK_CR;
            end
            else
            begin
                upd_trk = TRK_NONE;
                if (!upd_colon)
                begin
                    // Header name: compare case-folded against the length name
                    if (data_in == CH_COLON)
                    begin
                        upd_colon = 1'b1;
                    end
                    else
                    begin
                        if ((upd_pos == NAME_LEN) || (upper != name_char(upd_pos)))
                        begin
                            upd_mism = 1'b1;
                        end
                        if (upd_pos != NAME_LEN)
                        begin
                            upd_pos = upd_pos + 4'd1;
                        end
                    end
                end
                else if (val_active)
                begin
                    // Length value parse
                    case (upd_vst)
                        VS_LEAD:
                        begin
                            if (is_blank)
                            begin
                                upd_vst = VS_LEAD;
                            end
                            else if (data_in == CH_PLUS)
                            begin
                                upd_vst = VS_PLUS;
                            end
                            else if (data_in == CH_MINUS)
                            begin
                                upd_vst = VS_MINUS;
                            end
                            else if (is_digit)
                            begin
                                upd_vst = VS_DIGITS;
                                upd_len = acc_ovf ? '1 : acc_sum[LENGTH_BITS-1:0];
                                upd_ovf = upd_ovf || acc_ovf;
                            end
                            else
                            begin
                                upd_vst = VS_BAD;
                            end
                        end
                        VS_PLUS, VS_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                upd_vst = VS_DIGITS;
                                upd_len = acc_ovf ? '1 : acc_sum[LENGTH_BITS-1:0];
                                upd_ovf = upd_ovf || acc_ovf;
                            end
                            else if (is_blank && (upd_vst == VS_DIGITS))
                            begin
                                upd_vst = VS_TRAIL;
                            end
                            else
                            begin
                                upd_vst = VS_BAD;
                            end
                        end
                        VS_MINUS, VS_NEGZERO:
                        begin
                            if (is_digit)
                            begin
                                upd_vst = (data_in == CH_ZERO) ? VS_NEGZERO : VS_BAD;
                            end
                            else if (is_blank && (upd_vst == VS_NEGZERO))
                            begin
                                upd_vst = VS_TRAIL;
                            end
                            else
                            begin
                                upd_vst = VS_BAD;
                            end
                        end
                        VS_TRAIL:
                        begin
                            if (!is_blank)
                            begin
                                upd_vst = VS_BAD;
                            end
                        end
                        default:
                        begin
                            upd_vst = VS_BAD;
                        end
                    endcase
                end
            end

            // Header complete: enter body or end the request here
            if (hdone_flag)
            begin
                if (upd_capt && (upd_len != '0))
                begin
                    upd_phase = PH_BODY;
                    upd_rem   = upd_len;
                end
                else
                begin
                    rend_flag = 1'b1;
                end
            end
        end
    end

    // Request end returns everything to the idle header state
    always_comb
    begin
        phase_next = upd_phase;
        trk_next   = upd_trk;
        pos_next   = upd_pos;
        mism_next  = upd_mism;
        colon_next = upd_colon;
        capt_next  = upd_capt;
        vst_next   = upd_vst;
        len_next   = upd_len;
        inv_next   = upd_inv;
        ovf_next   = upd_ovf;
        rem_next   = upd_rem;
        sdone_next = upd_sdone;
        if (rend_flag)
        begin
            phase_next = PH_HEADER;
            trk_next   = TRK_NONE;
            pos_next   = '0;
            mism_next  = 1'b0;
            colon_next = 1'b0;
            capt_next  = 1'b0;
            vst_next   = VS_LEAD;
            len_next   = '0;
            inv_next   = 1'b0;
            ovf_next   = 1'b0;
            rem_next   = '0;
            sdone_next = 1'b0;
        end
    end

    // Reported length saturates to the 32-bit result field
    if (LENGTH_BITS > RESULT_LEN_W)
    begin : g_len_wide
        assign len_clip = (|upd_len[LENGTH_BITS-1:RESULT_LEN_W]) ?
                          '1 : upd_len[RESULT_LEN_W-1:0];
    end
    else
    begin : g_len_narrow
        assign len_clip = RESULT_LEN_W'(upd_len);
    end

    // Result word for the current byte
    always_comb
    begin
        result.data_out        = data_in;
        result.in_body         = body_flag;
        result.header_done     = hdone_flag;
        result.request_end     = rend_flag;
        result.has_length      = upd_capt;
        result.length_invalid  = upd_capt && upd_inv;
        result.length_overflow = upd_capt && upd_ovf;
        result.content_length  = upd_capt ? len_clip : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            trk_reg   <= TRK_NONE;
            pos_reg   <= '0;
            mism_reg  <= 1'b0;
            colon_reg <= 1'b0;
            capt_reg  <= 1'b0;
            vst_reg   <= VS_LEAD;
            len_reg   <= '0;
            inv_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            rem_reg   <= '0;
            sdone_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            trk_reg   <= trk_next;
            pos_reg   <= pos_next;
            mism_reg  <= mism_next;
            colon_reg <= colon_next;
            capt_reg  <= capt_next;
            vst_reg   <= vst_next;
            len_reg   <= len_next;
            inv_reg   <= inv_next;
            ovf_reg   <= ovf_next;
            rem_reg   <= rem_next;
            sdone_reg <= sdone_next;
        end
    end

endmodule

`default_nettype wire

[design/hrf_out_stage.sv]
// ----------------------------------------------------------------------------
// hrf_out_stage
// Result register: holds one framed word until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hrf_out_stage
    import hrf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire hrf_result_t  result,
    output logic              ready,
    hrf_out_if.source         tx
);

    logic        valid_reg;
    hrf_result_t result_reg;

    // Room for a new word when empty or when the held one is taken now
    assign ready = !valid_reg || tx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign tx.valid           = valid_reg;
    assign tx.data_out        = result_reg.data_out;
    assign tx.in_body         = result_reg.in_body;
    assign tx.header_done     = result_reg.header_done;
    assign tx.request_end     = result_reg.request_end;
    assign tx.has_length      = result_reg.has_length;
    assign tx.length_invalid  = result_reg.length_invalid;
    assign tx.length_overflow = result_reg.length_overflow;
    assign tx.content_length  = result_reg.content_length;

endmodule

`default_nettype wire

[design/http_request_framer.sv]
// ----------------------------------------------------------------------------
// http_request_framer
// Marks header, body and request end on a request byte stream.
// ----------------------------------------------------------------------------
// One byte is taken per clock while the consumer takes the output words, and
// one framed word comes out per byte, through the input register and then
// the result register. The rate is one word per cycle when not stalled, set
// by the framing state update in the core, which decides each byte from the
// state left by the previous one. The header ends on the first CR LF CR LF,
// CR LF LF or LF LF; a CONTENT-LENGTH line (case-insensitive) sets how many
// body bytes follow. LENGTH_BITS sets the width of the internal length
// counter; the reported length saturates at 32 bits.
`default_nettype none

module http_request_framer
    import hrf_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    hrf_in_if.sink     rx,
    hrf_out_if.source  tx
);

    logic        in_valid;
    logic [7:0]  in_data;
    logic        out_ready;
    logic        advance;
    hrf_result_t core_result;

    // A byte moves into the core when the result register has room
    assign advance = in_valid && out_ready;

    hrf_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .take  (advance),
        .valid (in_valid),
        .data  (in_data)
    );

    hrf_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .data_in (in_data),
        .result  (core_result)
    );

    hrf_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .result (core_result),
        .ready  (out_ready),
        .tx     (tx)
    );

endmodule

`default_nettype wire

[design/hrf_checker.sv]
// ----------------------------------------------------------------------------
// hrf_checker
// Port-level checks on the framed output words of the request framer.
// ----------------------------------------------------------------------------
`default_nettype none

module hrf_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        tx_valid,
    input wire logic        tx_ready,
    input wire logic [7:0]  data_out,
    input wire logic        in_body,
    input wire logic        header_done,
    input wire logic        request_end,
    input wire logic        has_length,
    input wire logic        length_invalid,
    input wire logic        length_overflow,
    input wire logic [31:0] content_length
);

    // A stalled word holds its valid and payload
    property p_stall_hold;
        @(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid && $stable(data_out) &&
            $stable(in_body) && $stable(request_end) && $stable(content_length);
    endproperty
    a_stall_hold: assert property (p_stall_hold)
        else $error("output word changed while stalled");

    // Body words only exist under a valid nonzero length
    property p_body_length;
        @(posedge clk) disable iff (!rst_n)
        tx_valid && in_body |-> has_length && !length_invalid &&
            (content_length != 32'd0);
    endproperty
    a_body_length: assert property (p_body_length)
        else $error("body word without a valid nonzero length");

    // The header delimiter is never a body word
    property p_hdone_header;
        @(posedge clk) disable iff (!rst_n)
        tx_valid && header_done |-> !in_body;
    endproperty
    a_hdone_header: assert property (p_hdone_header)
        else $error("header delimiter marked as body");

    // A header word ends a request only on the delimiter
    property p_header_end;
        @(posedge clk) disable iff (!rst_n)
        tx_valid && request_end && !in_body |-> header_done;
    endproperty
    a_header_end: assert property (p_header_end)
        else $error("request ended in header before the delimiter");

    // Length fields stay clear until a length line is taken
    property p_no_length;
        @(posedge clk) disable iff (!rst_n)
        tx_valid && !has_length |-> (content_length == 32'd0) &&
            !length_invalid && !length_overflow;
    endproperty
    a_no_length: assert property (p_no_length)
        else $error("length fields set without a length line");

endmodule

bind http_request_framer hrf_checker u_hrf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .tx_valid        (tx.valid),
    .tx_ready        (tx.ready),
    .data_out        (tx.data_out),
    .in_body         (tx.in_body),
    .header_done     (tx.header_done),
    .request_end     (tx.request_end),
    .has_length      (tx.has_length),
    .length_invalid  (tx.length_invalid),
    .length_overflow (tx.length_overflow),
    .content_length  (tx.content_length)
);

`default_nettype wire
